### sv/ptc_pkg.sv
// ----------------------------------------------------------------------------
// Pressure and temperature compensation package
// Widths, register indexes and limits shared by the compensation unit and its
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int TEMP_W  = 18;
    localparam int PRES_W  = 22;
    localparam int INDEX_W = 3;

    localparam logic [INDEX_W-1:0] REG_PRESSURE_SENS  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_PRESSURE_OFFSET = 3'd1;
    localparam logic [INDEX_W-1:0] REG_SENS_TEMPCO    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_OFFSET_TEMPCO  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_REFERENCE_TEMP = 3'd4;
    localparam logic [INDEX_W-1:0] REG_TEMP_SLOPE     = 3'd5;

    localparam int DT_W    = 25;
    localparam int PROD_W  = 42;
    localparam int TSUM_W  = 19;
    localparam int OFF_W   = 36;
    localparam int SENS_W  = 34;
    localparam int LO_W    = 17;
    localparam int HI_W    = 17;
    localparam int PLO_W   = 41;
    localparam int FULL_W  = 59;
    localparam int DIFF_W  = 39;
    localparam int PSUM_W  = 24;

    localparam int TEMP_SHIFT = 23;
    localparam int OFF_SHIFT  = 7;
    localparam int SENS_SHIFT = 8;
    localparam int MUL_SHIFT  = 21;
    localparam int PRES_SHIFT = 15;

    localparam logic signed [TSUM_W-1:0] TEMP_BASE = 19'sd2000;
    localparam logic signed [TSUM_W-1:0] TEMP_HI   = 19'sd131071;
    localparam logic signed [TSUM_W-1:0] TEMP_LO   = -19'sd131072;
    localparam logic signed [PSUM_W-1:0] PRES_HI   = 24'sd2097151;
    localparam logic signed [PSUM_W-1:0] PRES_LO   = -24'sd2097152;

endpackage

`default_nettype wire

### sv/ptc_raw_if.sv
// ----------------------------------------------------------------------------
// Raw conversion channel
// Carries one raw pressure and temperature conversion pair per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_raw_if;

    logic                        valid;
    logic                        ready;
    logic [ptc_pkg::RAW_W-1:0]   raw_pressure;
    logic [ptc_pkg::RAW_W-1:0]   raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);

endinterface

`default_nettype wire

### sv/ptc_comp_if.sv
// ----------------------------------------------------------------------------
// Compensated result channel
// Carries one compensated temperature and pressure pair per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptc_comp_if;

    logic                              valid;
    logic                              ready;
    logic signed [ptc_pkg::TEMP_W-1:0] temperature_centi;
    logic signed [ptc_pkg::PRES_W-1:0] pressure_centi;

    modport source (output valid, output temperature_centi, output pressure_centi, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_centi, output ready);

endinterface

`default_nettype wire

### sv/pressure_temp_compensation_unit.sv
// ----------------------------------------------------------------------------
// Pressure and temperature compensation unit
// First-order barometer compensation of raw conversion pairs with six
// calibration coefficients, giving hundredths of a degree and of a millibar.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while the output is not stalled, and
// passes each request through a six-stage pipeline: temperature difference,
// three coefficient products, offset and sensitivity sums, the two partial
// products of raw pressure times sensitivity, their combination, and the
// final subtract, shift and saturation in the output register. Each stage
// holds its own valid bit, so a stalled output lets bubbles close up and
// requests keep coming in until the pipeline is full. Calibration words are
// written through the write port; the user must write them only while no
// request is in flight, as the unit itself does not enforce it.
`default_nettype none

module pressure_temp_compensation_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ptc_pkg::INDEX_W-1:0]  cfg_index,
    input  wire logic [ptc_pkg::COEF_W-1:0]   cfg_wdata,
    ptc_raw_if.sink                           raw,
    ptc_comp_if.source                        comp
);

    logic [ptc_pkg::COEF_W-1:0] sens_coef_reg;
    logic [ptc_pkg::COEF_W-1:0] offset_coef_reg;
    logic [ptc_pkg::COEF_W-1:0] sens_tc_coef_reg;
    logic [ptc_pkg::COEF_W-1:0] offset_tc_coef_reg;
    logic [ptc_pkg::COEF_W-1:0] ref_temp_coef_reg;
    logic [ptc_pkg::COEF_W-1:0] temp_slope_coef_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    logic s1_en, s2_en, s3_en, s4_en, s5_en, out_en;

    logic signed [ptc_pkg::DT_W-1:0]   s1_dt_reg, s1_dt_next;
    logic [ptc_pkg::RAW_W-1:0]         s1_d1_reg;

    logic signed [ptc_pkg::PROD_W-1:0] s2_p6_reg, s2_p6_next;
    logic signed [ptc_pkg::PROD_W-1:0] s2_p4_reg, s2_p4_next;
    logic signed [ptc_pkg::PROD_W-1:0] s2_p3_reg, s2_p3_next;
    logic [ptc_pkg::RAW_W-1:0]         s2_d1_reg;

    logic signed [ptc_pkg::TSUM_W-1:0] s3_temp_reg, s3_temp_next;
    logic signed [ptc_pkg::OFF_W-1:0]  s3_off_reg, s3_off_next;
    logic signed [ptc_pkg::SENS_W-1:0] s3_sens_reg, s3_sens_next;
    logic [ptc_pkg::RAW_W-1:0]         s3_d1_reg;

    logic signed [ptc_pkg::TEMP_W-1:0] s4_temp_reg, s4_temp_next;
    logic signed [ptc_pkg::OFF_W-1:0]  s4_off_reg;
    logic [ptc_pkg::PLO_W-1:0]         s4_plo_reg, s4_plo_next;
    logic signed [ptc_pkg::PROD_W-1:0] s4_phi_reg, s4_phi_next;

    logic signed [ptc_pkg::TEMP_W-1:0] s5_temp_reg;
    logic signed [ptc_pkg::OFF_W-1:0]  s5_off_reg;
    logic signed [ptc_pkg::FULL_W-1:0] s5_full_reg, s5_full_next;

    logic signed [ptc_pkg::TEMP_W-1:0] out_temp_reg;
    logic signed [ptc_pkg::PRES_W-1:0] out_pres_reg, out_pres_next;

    logic signed [ptc_pkg::DIFF_W-1:0] pres_diff;
    logic signed [ptc_pkg::PSUM_W-1:0] pres_sum;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_coef_reg       <= '0;
            offset_coef_reg     <= '0;
            sens_tc_coef_reg    <= '0;
            offset_tc_coef_reg  <= '0;
            ref_temp_coef_reg   <= '0;
            temp_slope_coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptc_pkg::REG_PRESSURE_SENS:   sens_coef_reg       <= cfg_wdata;
                ptc_pkg::REG_PRESSURE_OFFSET: offset_coef_reg     <= cfg_wdata;
                ptc_pkg::REG_SENS_TEMPCO:     sens_tc_coef_reg    <= cfg_wdata;
                ptc_pkg::REG_OFFSET_TEMPCO:   offset_tc_coef_reg  <= cfg_wdata;
                ptc_pkg::REG_REFERENCE_TEMP:  ref_temp_coef_reg   <= cfg_wdata;
                ptc_pkg::REG_TEMP_SLOPE:      temp_slope_coef_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Each stage loads when it is empty or its contents move on.
    assign out_en = !out_valid_reg || comp.ready;
    assign s5_en  = !s5_valid_reg || out_en;
    assign s4_en  = !s4_valid_reg || s5_en;
    assign s3_en  = !s3_valid_reg || s4_en;
    assign s2_en  = !s2_valid_reg || s3_en;
    assign s1_en  = !s1_valid_reg || s2_en;
    assign raw.ready = s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= raw.valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_en)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s5_valid_reg;
            end
        end
    end

    // Stage 1: temperature difference from the reference.
    assign s1_dt_next = $signed({1'b0, raw.raw_temperature})
                      - $signed({1'b0, ref_temp_coef_reg, 8'h00});

    // Stage 2: the three products of the temperature difference.
    assign s2_p6_next = $signed({{(ptc_pkg::PROD_W-ptc_pkg::DT_W){s1_dt_reg[ptc_pkg::DT_W-1]}},
                                 s1_dt_reg}
                              * {{(ptc_pkg::PROD_W-ptc_pkg::COEF_W){1'b0}}, temp_slope_coef_reg});
    assign s2_p4_next = $signed({{(ptc_pkg::PROD_W-ptc_pkg::DT_W){s1_dt_reg[ptc_pkg::DT_W-1]}},
                                 s1_dt_reg}
                              * {{(ptc_pkg::PROD_W-ptc_pkg::COEF_W){1'b0}}, offset_tc_coef_reg});
    assign s2_p3_next = $signed({{(ptc_pkg::PROD_W-ptc_pkg::DT_W){s1_dt_reg[ptc_pkg::DT_W-1]}},
                                 s1_dt_reg}
                              * {{(ptc_pkg::PROD_W-ptc_pkg::COEF_W){1'b0}}, sens_tc_coef_reg});

    // Stage 3: temperature, offset and sensitivity.
    assign s3_temp_next = ptc_pkg::TEMP_BASE
                        + $signed(s2_p6_reg[ptc_pkg::PROD_W-1:ptc_pkg::TEMP_SHIFT]);
    assign s3_off_next  = $signed({4'h0, offset_coef_reg, 16'h0000})
                        + $signed({s2_p4_reg[ptc_pkg::PROD_W-1],
                                   s2_p4_reg[ptc_pkg::PROD_W-1:ptc_pkg::OFF_SHIFT]});
    assign s3_sens_next = $signed({3'b000, sens_coef_reg, 15'h0000})
                        + $signed(s2_p3_reg[ptc_pkg::PROD_W-1:ptc_pkg::SENS_SHIFT]);

    // Stage 4: raw pressure times sensitivity as two partial products.
    assign s4_plo_next = {{(ptc_pkg::PLO_W-ptc_pkg::RAW_W){1'b0}}, s3_d1_reg}
                       * {{(ptc_pkg::PLO_W-ptc_pkg::LO_W){1'b0}}, s3_sens_reg[ptc_pkg::LO_W-1:0]};
    assign s4_phi_next = $signed({{(ptc_pkg::PROD_W-ptc_pkg::RAW_W){1'b0}}, s3_d1_reg}
                       * {{(ptc_pkg::PROD_W-ptc_pkg::HI_W){s3_sens_reg[ptc_pkg::SENS_W-1]}},
                          s3_sens_reg[ptc_pkg::SENS_W-1:ptc_pkg::LO_W]});

    always_comb
    begin
        if (s3_temp_reg > ptc_pkg::TEMP_HI)
        begin
            s4_temp_next = ptc_pkg::TEMP_HI[ptc_pkg::TEMP_W-1:0];
        end
        else if (s3_temp_reg < ptc_pkg::TEMP_LO)
        begin
            s4_temp_next = ptc_pkg::TEMP_LO[ptc_pkg::TEMP_W-1:0];
        end
        else
        begin
            s4_temp_next = s3_temp_reg[ptc_pkg::TEMP_W-1:0];
        end
    end

    // Stage 5: combine the partial products.
    assign s5_full_next = $signed({s4_phi_reg, {ptc_pkg::LO_W{1'b0}}})
                        + $signed({{(ptc_pkg::FULL_W-ptc_pkg::PLO_W){1'b0}}, s4_plo_reg});

    // Output stage: subtract the offset, scale and saturate.
    assign pres_diff = $signed({s5_full_reg[ptc_pkg::FULL_W-1],
                                s5_full_reg[ptc_pkg::FULL_W-1:ptc_pkg::MUL_SHIFT]})
                     - $signed({{(ptc_pkg::DIFF_W-ptc_pkg::OFF_W){s5_off_reg[ptc_pkg::OFF_W-1]}},
                                s5_off_reg});
    assign pres_sum  = $signed(pres_diff[ptc_pkg::DIFF_W-1:ptc_pkg::PRES_SHIFT]);

    always_comb
    begin
        if (pres_sum > ptc_pkg::PRES_HI)
        begin
            out_pres_next = ptc_pkg::PRES_HI[ptc_pkg::PRES_W-1:0];
        end
        else if (pres_sum < ptc_pkg::PRES_LO)
        begin
            out_pres_next = ptc_pkg::PRES_LO[ptc_pkg::PRES_W-1:0];
        end
        else
        begin
            out_pres_next = pres_sum[ptc_pkg::PRES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_dt_reg <= s1_dt_next;
            s1_d1_reg <= raw.raw_pressure;
        end
        if (s2_en)
        begin
            s2_p6_reg <= s2_p6_next;
            s2_p4_reg <= s2_p4_next;
            s2_p3_reg <= s2_p3_next;
            s2_d1_reg <= s1_d1_reg;
        end
        if (s3_en)
        begin
            s3_temp_reg <= s3_temp_next;
            s3_off_reg  <= s3_off_next;
            s3_sens_reg <= s3_sens_next;
            s3_d1_reg   <= s2_d1_reg;
        end
        if (s4_en)
        begin
            s4_temp_reg <= s4_temp_next;
            s4_off_reg  <= s3_off_reg;
            s4_plo_reg  <= s4_plo_next;
            s4_phi_reg  <= s4_phi_next;
        end
        if (s5_en)
        begin
            s5_temp_reg <= s4_temp_reg;
            s5_off_reg  <= s4_off_reg;
            s5_full_reg <= s5_full_next;
        end
        if (out_en)
        begin
            out_temp_reg <= s5_temp_reg;
            out_pres_reg <= out_pres_next;
        end
    end

    assign comp.valid             = out_valid_reg;
    assign comp.temperature_centi = out_temp_reg;
    assign comp.pressure_centi    = out_pres_reg;

endmodule

`default_nettype wire
